>>> rtl/plbc_pkg.sv
// ----------------------------------------------------------------------------
// plbc_pkg: shared types and constants of the block cache controller
// Command codes, payload structs and controller/datapath command structs.
// ----------------------------------------------------------------------------
package plbc_pkg;

  localparam int SLOTS_DEF = 16;
  localparam logic [3:0] SPB_RESET = 4'd2;
  localparam logic [7:0] PIN_MAX = 8'hFF;

  typedef enum logic [1:0] {
    CMD_GET     = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_DIRTY   = 2'd2,
    CMD_SYNC    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    OP_NONE  = 2'd0,
    OP_READ  = 2'd1,
    OP_WRITE = 2'd2
  } disk_op_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] block_number;
    logic [3:0]  slot_index;
    logic [31:0] timestamp;
  } in_item_t;

  typedef struct packed {
    logic        status;
    logic [3:0]  result_slot;
    logic        was_hit;
    logic [1:0]  disk_operation;
    logic [34:0] disk_sector;
    logic [3:0]  disk_slot;
    logic        last_result;
    logic [63:0] hit_total;
    logic [63:0] miss_total;
  } out_item_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;      // capture input item, start a scan
    logic scan;      // examine one slot
    logic do_hit;    // apply hit update
    logic do_fill;   // apply miss fill
    logic do_simple; // release or mark dirty
    logic do_sync;   // clear dirty of current sync slot
    logic clr_sel;   // count one get miss
    logic [2:0] emit; // result kind
  } dp_cmd_t;

  localparam logic [2:0] EM_HIT = 3'd0, EM_FULL = 3'd1, EM_WB = 3'd2,
    EM_READ = 3'd3, EM_ACK = 3'd4, EM_SYNCW = 3'd5, EM_SYNC0 = 3'd6;

  // Datapath to controller status.
  typedef struct packed {
    logic scan_done;
    logic hit;
    logic have_free;
    logic have_clean;
    logic have_dirty;
    logic sync_found;  // a dirty valid slot found, the lowest one
    logic sync_more;   // another dirty slot after it
    logic [1:0] command;
  } dp_sts_t;

endpackage

>>> rtl/pinned_lru_block_cache_controller_unit.sv
// ----------------------------------------------------------------------------
// pinned_lru_block_cache_controller_unit: write-back block cache controller
// Tag and replacement policy for a pinned LRU disk block cache.
// ----------------------------------------------------------------------------
// Usage: commands enter on the in_ channel (valid/ready), one beat each.
// Results leave on the out_ channel; a command gives one or more beats, the
// final one carrying last_result. A miss on a dirty victim gives a write-back
// beat then a read beat; a sync gives one write beat per dirty slot, or a
// single beat with no disk request if none is dirty. A get scans one slot
// per cycle before its first result; a sync sends its write beats one per
// cycle while out_ready is high. One command is in work at a time; in_ready
// is high only between commands, so the next command is taken in the cycle
// after the final beat of the previous one is accepted.
// cfg_we writes the block size in sectors; the user must write it only while
// idle, which the block does not enforce. Reset (synchronous, rst_n low)
// clears all slots and counters and sets the block size to 2 sectors. When
// the receiver stalls, the pending result beat holds and the block waits.
// ----------------------------------------------------------------------------
module pinned_lru_block_cache_controller_unit #(
  parameter int SLOTS = plbc_pkg::SLOTS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [3:0]          cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  plbc_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output plbc_pkg::out_item_t out_data
);
  plbc_pkg::dp_cmd_t cmd;
  plbc_pkg::dp_sts_t sts;

  plbc_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .sts(sts), .cmd(cmd)
  );

  plbc_datapath #(.SLOTS(SLOTS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .item(in_data), .cmd(cmd), .sts(sts), .result(out_data)
  );

  // No new command is taken while a result beat waits.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("input taken while result pending");

  // A write-back beat is never the final beat of a get.
  a_wb_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.disk_operation == plbc_pkg::OP_WRITE &&
     out_data.result_slot != 4'd0) |-> !out_data.last_result)
    else $error("write-back marked final");

  // A full status never comes with a disk request.
  a_full_nodisk: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status) |-> out_data.disk_operation == plbc_pkg::OP_NONE)
    else $error("full status with disk request");
endmodule

>>> rtl/plbc_datapath.sv
// ----------------------------------------------------------------------------
// plbc_datapath: slot tables, sequential slot scan, counters, result build
// Scans one slot per cycle for hit, free, oldest clean and oldest dirty.
// ----------------------------------------------------------------------------
module plbc_datapath #(
  parameter int SLOTS = plbc_pkg::SLOTS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [3:0]          cfg_data,
  input  plbc_pkg::in_item_t  item,
  input  plbc_pkg::dp_cmd_t   cmd,
  output plbc_pkg::dp_sts_t   sts,
  output plbc_pkg::out_item_t result
);
  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);

  logic [SLOTS-1:0] valid_r, dirty_r;
  logic [31:0] tag_r [SLOTS];
  logic [7:0]  pin_r [SLOTS];
  logic [31:0] time_r [SLOTS];
  logic [63:0] hits_r, misses_r;
  logic [3:0]  spb_r;
  plbc_pkg::in_item_t it_r;
  logic [CW-1:0] cur_r;
  logic hit_r, free_r, cln_r, drt_r;
  logic [IW-1:0] hit_i_r, free_i_r, cln_i_r, drt_i_r;
  logic [31:0] cln_t_r, drt_t_r;
  logic [IW-1:0] ci;
  logic [IW-1:0] vic;
  logic [IW-1:0] sidx;
  logic sidx_ok;

  assign ci = cur_r[IW-1:0];
  assign vic = free_r ? free_i_r : (cln_r ? cln_i_r : drt_i_r);
  assign sidx_ok = ({28'd0, it_r.slot_index} < 32'(SLOTS));
  assign sidx = IW'(it_r.slot_index);

  // Sync: find lowest dirty valid slot, and whether there is a second.
  logic [SLOTS-1:0] dv;
  logic sf, sm;
  logic [IW-1:0] si;
  assign dv = valid_r & dirty_r;
  always_comb begin
    sf = 1'b0; sm = 1'b0; si = '0;
    for (int k = 0; k < SLOTS; k++) begin
      if (dv[k]) begin
        if (sf) sm = 1'b1;
        else begin sf = 1'b1; si = IW'(k); end
      end
    end
  end

  assign sts.scan_done = (cur_r == CW'(SLOTS));
  assign sts.hit = hit_r;
  assign sts.have_free = free_r;
  assign sts.have_clean = cln_r;
  assign sts.have_dirty = drt_r;
  assign sts.sync_found = sf;
  assign sts.sync_more = sm;
  assign sts.command = it_r.command;

  // Sector product for the selected tag.
  logic [31:0] stag;
  logic [35:0] prod;
  always_comb begin
    case (cmd.emit)
      plbc_pkg::EM_WB:    stag = tag_r[vic];
      plbc_pkg::EM_READ:  stag = it_r.block_number;
      plbc_pkg::EM_SYNCW: stag = tag_r[si];
      default:            stag = '0;
    endcase
  end
  assign prod = stag * spb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0; dirty_r <= '0; hits_r <= '0; misses_r <= '0;
      spb_r <= plbc_pkg::SPB_RESET; cur_r <= '0;
      hit_r <= 1'b0; free_r <= 1'b0; cln_r <= 1'b0; drt_r <= 1'b0;
      for (int k = 0; k < SLOTS; k++) begin
        tag_r[k] <= '0; pin_r[k] <= '0; time_r[k] <= '0;
      end
    end else begin
      if (cfg_we) spb_r <= cfg_data;
      if (cmd.load) begin
        it_r <= item; cur_r <= '0;
        hit_r <= 1'b0; free_r <= 1'b0; cln_r <= 1'b0; drt_r <= 1'b0;
      end
      // One slot per cycle: hit, lowest free, oldest clean/dirty unpinned.
      if (cmd.scan) begin
        cur_r <= cur_r + CW'(1);
        if (valid_r[ci] && tag_r[ci] == it_r.block_number && !hit_r) begin
          hit_r <= 1'b1; hit_i_r <= ci;
        end
        if (!valid_r[ci] && !free_r) begin
          free_r <= 1'b1; free_i_r <= ci;
        end
        if (valid_r[ci] && pin_r[ci] == 8'd0) begin
          if (!dirty_r[ci] && (!cln_r || time_r[ci] < cln_t_r)) begin
            cln_r <= 1'b1; cln_i_r <= ci; cln_t_r <= time_r[ci];
          end
          if (dirty_r[ci] && (!drt_r || time_r[ci] < drt_t_r)) begin
            drt_r <= 1'b1; drt_i_r <= ci; drt_t_r <= time_r[ci];
          end
        end
      end
      if (cmd.do_hit) begin
        hits_r <= hits_r + 64'd1;
        if (pin_r[hit_i_r] != plbc_pkg::PIN_MAX) pin_r[hit_i_r] <= pin_r[hit_i_r] + 8'd1;
        time_r[hit_i_r] <= it_r.timestamp;
      end
      if (cmd.do_fill) begin
        valid_r[vic] <= 1'b1; dirty_r[vic] <= 1'b0;
        tag_r[vic] <= it_r.block_number; pin_r[vic] <= 8'd1;
        time_r[vic] <= it_r.timestamp;
      end
      if (cmd.clr_sel) misses_r <= misses_r + 64'd1;
      if (cmd.do_simple && sidx_ok) begin
        if (it_r.command == plbc_pkg::CMD_RELEASE) begin
          if (pin_r[sidx] != 8'd0) pin_r[sidx] <= pin_r[sidx] - 8'd1;
        end else dirty_r[sidx] <= 1'b1;
      end
      if (cmd.do_sync) begin
        dirty_r[si] <= 1'b0;
      end
    end
  end

  // Result fields; counters shown after this command's updates.
  always_comb begin
    result = '0;
    result.hit_total = hits_r;
    result.miss_total = misses_r;
    result.last_result = 1'b1;
    case (cmd.emit)
      plbc_pkg::EM_HIT: begin
        result.result_slot = 4'(hit_i_r); result.was_hit = 1'b1;
      end
      plbc_pkg::EM_FULL: result.status = 1'b1;
      plbc_pkg::EM_WB: begin
        result.result_slot = 4'(vic); result.disk_operation = plbc_pkg::OP_WRITE;
        result.disk_sector = prod[34:0]; result.disk_slot = 4'(vic);
        result.last_result = 1'b0;
      end
      plbc_pkg::EM_READ: begin
        result.result_slot = 4'(vic); result.disk_operation = plbc_pkg::OP_READ;
        result.disk_sector = prod[34:0]; result.disk_slot = 4'(vic);
      end
      plbc_pkg::EM_ACK: result.result_slot = it_r.slot_index;
      plbc_pkg::EM_SYNCW: begin
        result.disk_operation = plbc_pkg::OP_WRITE;
        result.disk_sector = prod[34:0]; result.disk_slot = 4'(si);
        result.last_result = !sm;
      end
      default: ;
    endcase
  end
endmodule

>>> rtl/plbc_ctrl.sv
// ----------------------------------------------------------------------------
// plbc_ctrl: command sequencer of the block cache controller
// Steps each command through scan, update and result beats.
// ----------------------------------------------------------------------------
module plbc_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  plbc_pkg::dp_sts_t   sts,
  output plbc_pkg::dp_cmd_t   cmd
);
  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_SCAN = 7'b0000010,
    S_DEC  = 7'b0000100,
    S_WB   = 7'b0001000,
    S_OUT  = 7'b0010000,
    S_SYNC = 7'b0100000,
    S_SEND = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic [2:0] em_r, em_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; em_r <= plbc_pkg::EM_ACK;
    end else begin
      state_r <= state_nxt; em_r <= em_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);
  assign out_valid = (state_r == S_WB) || (state_r == S_OUT) || (state_r == S_SEND);

  always_comb begin
    state_nxt = state_r; em_nxt = em_r; cmd = '0; cmd.emit = em_r;
    unique case (state_r)
      S_IDLE: if (in_valid) begin
        cmd.load = 1'b1; state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (sts.command == plbc_pkg::CMD_SYNC) state_nxt = S_SYNC;
        else if (sts.command != plbc_pkg::CMD_GET) begin
          cmd.do_simple = 1'b1; em_nxt = plbc_pkg::EM_ACK; state_nxt = S_OUT;
        end else if (sts.scan_done) state_nxt = S_DEC;
        else cmd.scan = 1'b1;
      end
      S_DEC: begin
        if (sts.hit) begin
          cmd.do_hit = 1'b1; em_nxt = plbc_pkg::EM_HIT; state_nxt = S_OUT;
        end else begin
          cmd.clr_sel = 1'b1;
          if (sts.have_free || sts.have_clean) begin
            em_nxt = plbc_pkg::EM_READ; state_nxt = S_OUT;
          end else if (sts.have_dirty) begin
            em_nxt = plbc_pkg::EM_WB; state_nxt = S_WB;
          end else begin
            em_nxt = plbc_pkg::EM_FULL; state_nxt = S_OUT;
          end
        end
      end
      S_WB: if (out_ready) begin
        em_nxt = plbc_pkg::EM_READ; state_nxt = S_OUT;
      end
      S_OUT: if (out_ready) begin
        if (em_r == plbc_pkg::EM_READ) cmd.do_fill = 1'b1;
        state_nxt = S_IDLE;
      end
      S_SYNC: begin
        if (sts.sync_found) begin
          em_nxt = plbc_pkg::EM_SYNCW; state_nxt = S_SEND;
        end else begin
          em_nxt = plbc_pkg::EM_SYNC0; state_nxt = S_OUT;
        end
      end
      S_SEND: if (out_ready) begin
        cmd.do_sync = 1'b1;
        state_nxt = sts.sync_more ? S_SEND : S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end
endmodule
